### sv/jbt_pkg.sv
package jbt_pkg;

  localparam int POS_BITS_DEF = 16;

  // Token kinds.
  localparam logic [3:0] TK_LBRACE = 4'd0;
  localparam logic [3:0] TK_RBRACE = 4'd1;
  localparam logic [3:0] TK_LBRACK = 4'd2;
  localparam logic [3:0] TK_RBRACK = 4'd3;
  localparam logic [3:0] TK_COLON  = 4'd4;
  localparam logic [3:0] TK_COMMA  = 4'd5;
  localparam logic [3:0] TK_STRING = 4'd6;
  localparam logic [3:0] TK_NUMBER = 4'd7;
  localparam logic [3:0] TK_FALSE  = 4'd8;
  localparam logic [3:0] TK_TRUE   = 4'd9;
  localparam logic [3:0] TK_NULL   = 4'd10;
  localparam logic [3:0] TK_END    = 4'd11;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_VALUE    = 3'd1;
  localparam logic [2:0] ERR_UNICODE  = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_UNCLOSED = 3'd4;
  localparam logic [2:0] ERR_NUMBER   = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] start_column;
    logic [15:0] end_column;
    logic        number_is_real;
    logic        last_of_run;
  } out_item_t;

  // Up to three results caused by one byte, in order from item[0].
  typedef struct packed {
    logic [1:0]            count;
    out_item_t [2:0]       item;
  } res_bundle_t;

endpackage

### sv/json_byte_tokenizer_top.sv
// Streaming JSON lexer. Feed the document one byte per item on the in_ channel,
// with end_of_text set on its final byte; tokens and errors come out on the
// out_ channel, each with a zero-based line and the first and last column of
// its span, and last_of_run marks the final result caused by one byte. A byte
// is registered on acceptance and scanned from the input register, and its results
// are registered in the three-slot result register. The block takes one byte per
// cycle as long as each byte causes at most one result and out_ready stays high.
// A byte that causes k results (up to three, for example a number closed by a
// comma on the final byte) occupies the three-slot result register, and the next
// byte waits in the input register until those results have been taken. After an
// error result the block stays silent until the end of the document, and the
// end token is then not sent. Positions count in POSITION_BITS bits and
// saturate; the output fields saturate at 65535.
module json_byte_tokenizer_top import jbt_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  in_item_t    in_item_r;
  logic        in_vld_r;
  logic        step;
  logic        can_load;
  res_bundle_t bundle;

  // A held byte is scanned when its results have room, or when it causes none.
  assign step     = in_vld_r && (can_load || bundle.count == 2'd0);
  assign in_ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  jbt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_item (in_item_r),
    .bundle  (bundle)
  );

  jbt_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Results produced by a scanned byte show up on the output in the next cycle.
  a_results_shown: assert property (@(posedge clk) disable iff (!rst_n)
    step && bundle.count != 2'd0 |=> out_valid)
    else $error("scanned results did not reach the output");

  // A result that is not the last of its run is always followed by another.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("run of results ended without last_of_run");

  // Error results carry kind zero and no real flag.
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_NONE |->
      out_data.token_kind == TK_LBRACE && !out_data.number_is_real)
    else $error("error result with token fields set");
`endif

endmodule

### sv/jbt_scan.sv
module jbt_scan import jbt_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    in_item,
  output res_bundle_t bundle
);

  localparam int PB = POSITION_BITS;
  localparam int PW = (PB > 16) ? PB : 16;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_STR    = 3'd1;
  localparam logic [2:0] M_ESC    = 3'd2;
  localparam logic [2:0] M_UNI    = 3'd3;
  localparam logic [2:0] M_UNIBAD = 3'd4;
  localparam logic [2:0] M_NUM    = 3'd5;
  localparam logic [2:0] M_KW     = 3'd6;
  localparam logic [2:0] M_BAD    = 3'd7;

  localparam logic [2:0] NF_POINT = 3'b001;
  localparam logic [2:0] NF_EXP   = 3'b010;
  localparam logic [2:0] NF_BAD   = 3'b100;

  localparam logic [3:0] KW_FALSE = 4'd5;
  localparam logic [3:0] KW_TRUE  = 4'd9;
  localparam logic [3:0] KW_NULL  = 4'd13;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  typedef struct packed {
    logic      hit;
    logic      fail;
    out_item_t res;
  } fw_t;

  logic [2:0]    mode_r, mode_nxt;
  logic [2:0]    hex_r, hex_nxt;
  logic [2:0]    nf_r, nf_nxt;
  logic [3:0]    kw_r, kw_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [PB-1:0] line_r, line_nxt;
  logic [PB-1:0] col_r, col_nxt;
  logic [PB-1:0] ts_r, ts_nxt;
  logic [PB-1:0] eb_r, eb_nxt;
  logic          err_r, err_nxt;

  logic [7:0]      c;
  logic            eot;
  logic [1:0]      n;
  out_item_t [2:0] res;
  fw_t             fw;

  logic       st_punct;
  logic       st_space;
  logic [3:0] st_kind;
  logic [2:0] st_mode;
  logic [3:0] st_kw;

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch >= 8'd9 && ch <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  endfunction

  function automatic logic is_hex(input logic [7:0] ch);
    return is_digit(ch) || (ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46);
  endfunction

  function automatic logic is_term(input logic [7:0] ch);
    return is_space(ch) || ch == CH_COMMA || ch == CH_RBRC || ch == CH_RBRK;
  endfunction

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (&v) ? v : v + PB'(1);
  endfunction

  function automatic logic [15:0] to16(input logic [PB-1:0] v);
    logic [PW-1:0] w;
    w = PW'(v);
    return (w > PW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  // Letters of false, true and null laid end to end.
  function automatic logic [7:0] kw_char(input logic [3:0] s);
    case (s)
      4'd0:    kw_char = 8'h66;
      4'd1:    kw_char = 8'h61;
      4'd2:    kw_char = 8'h6C;
      4'd3:    kw_char = 8'h73;
      4'd4:    kw_char = 8'h65;
      4'd5:    kw_char = 8'h74;
      4'd6:    kw_char = 8'h72;
      4'd7:    kw_char = 8'h75;
      4'd8:    kw_char = 8'h65;
      4'd9:    kw_char = 8'h6E;
      4'd10:   kw_char = 8'h75;
      4'd11:   kw_char = 8'h6C;
      4'd12:   kw_char = 8'h6C;
      default: kw_char = 8'h00;
    endcase
  endfunction

  function automatic out_item_t mk_res(input logic [3:0] kind, input logic [2:0] code,
                                       input logic [PB-1:0] line, input logic [PB-1:0] s,
                                       input logic [PB-1:0] e, input logic is_real);
    out_item_t r;
    r.token_kind     = kind;
    r.error_code     = code;
    r.line_number    = to16(line);
    r.start_column   = to16(s);
    r.end_column     = to16(e);
    r.number_is_real = is_real;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  function automatic fw_t finish_word(input logic [2:0] mode, input logic [2:0] nf,
                                      input logic [3:0] kw, input logic [7:0] p,
                                      input logic [PB-1:0] ts, input logic [PB-1:0] last,
                                      input logic [PB-1:0] line);
    fw_t f;
    f = '0;
    if (mode == M_NUM) begin
      f.hit = 1'b1;
      if ((nf & NF_BAD) != 3'd0 || p == CH_MINUS || p == CH_POINT || p == 8'h65) begin
        f.fail = 1'b1;
        f.res  = mk_res(TK_LBRACE, ERR_NUMBER, line, ts, last, 1'b0);
      end else begin
        f.res = mk_res(TK_NUMBER, ERR_NONE, line, ts, last,
                       (nf & (NF_POINT | NF_EXP)) != 3'd0);
      end
    end else if (mode == M_KW) begin
      f.hit = 1'b1;
      if (kw == KW_FALSE) begin
        f.res = mk_res(TK_FALSE, ERR_NONE, line, ts, last, 1'b0);
      end else if (kw == KW_TRUE) begin
        f.res = mk_res(TK_TRUE, ERR_NONE, line, ts, last, 1'b0);
      end else if (kw == KW_NULL) begin
        f.res = mk_res(TK_NULL, ERR_NONE, line, ts, last, 1'b0);
      end else begin
        f.fail = 1'b1;
        f.res  = mk_res(TK_LBRACE, ERR_VALUE, line, ts, last, 1'b0);
      end
    end else if (mode == M_BAD) begin
      f.hit  = 1'b1;
      f.fail = 1'b1;
      f.res  = mk_res(TK_LBRACE, ERR_VALUE, line, ts, last, 1'b0);
    end
    return f;
  endfunction

  function automatic fw_t line_end(input logic [2:0] mode, input logic [2:0] nf,
                                   input logic [3:0] kw, input logic [7:0] p,
                                   input logic [PB-1:0] ts, input logic [PB-1:0] eb,
                                   input logic [PB-1:0] col, input logic [PB-1:0] line);
    fw_t f;
    logic [PB-1:0] last;
    last = (col == '0) ? '0 : col - PB'(1);
    f = '0;
    case (mode)
      M_STR, M_ESC: begin
        f.hit  = 1'b1;
        f.fail = 1'b1;
        f.res  = mk_res(TK_LBRACE, ERR_UNCLOSED, line, ts, last, 1'b0);
      end
      M_UNI, M_UNIBAD: begin
        f.hit  = 1'b1;
        f.fail = 1'b1;
        f.res  = mk_res(TK_LBRACE, ERR_UNICODE, line, eb, last, 1'b0);
      end
      M_NUM, M_KW, M_BAD: begin
        f = finish_word(mode, nf, kw, p, ts, last, line);
      end
      default: begin
        f = '0;
      end
    endcase
    return f;
  endfunction

  function automatic logic [2:0] number_byte(input logic [7:0] ch, input logic [7:0] p,
                                             input logic [2:0] nf);
    logic [2:0] f;
    f = nf;
    if ((p == CH_MINUS || p == CH_POINT) && !is_digit(ch)) f = f | NF_BAD;
    if (p == 8'h65 && !is_digit(ch) && ch != CH_MINUS) f = f | NF_BAD;
    if (ch == CH_MINUS) begin
      if (p != 8'h65) f = f | NF_BAD;
    end else if (ch == CH_POINT) begin
      if ((f & (NF_POINT | NF_EXP)) != 3'd0 || !is_digit(p)) f = f | NF_BAD;
      else f = f | NF_POINT;
    end else if (ch == 8'h65) begin
      if ((f & NF_EXP) != 3'd0 || !is_digit(p)) f = f | NF_BAD;
      else f = f | NF_EXP;
    end else if (!is_digit(ch)) begin
      f = f | NF_BAD;
    end
    return f;
  endfunction

  function automatic logic [3:0] keyword_byte(input logic [7:0] ch, input logic [3:0] s);
    if (s != 4'd0 && s != KW_FALSE && s != KW_TRUE && s < KW_NULL && ch == kw_char(s)) begin
      return s + 4'd1;
    end
    return 4'd0;
  endfunction

  assign c   = in_item.text_byte;
  assign eot = in_item.end_of_text;

  // How this byte would open a token from the idle state.
  always_comb begin
    st_punct = 1'b1;
    st_kind  = TK_LBRACE;
    case (c)
      CH_LBRC:  st_kind = TK_LBRACE;
      CH_RBRC:  st_kind = TK_RBRACE;
      CH_LBRK:  st_kind = TK_LBRACK;
      CH_RBRK:  st_kind = TK_RBRACK;
      CH_COLON: st_kind = TK_COLON;
      CH_COMMA: st_kind = TK_COMMA;
      default:  st_punct = 1'b0;
    endcase
    st_space = is_space(c);
    st_kw    = 4'd0;
    if (c == CH_QUOTE) begin
      st_mode = M_STR;
    end else if (c == CH_MINUS || is_digit(c)) begin
      st_mode = M_NUM;
    end else if (is_alpha(c)) begin
      st_mode = M_KW;
      st_kw   = (c == 8'h66) ? 4'd1 : (c == 8'h74) ? 4'd6 : (c == 8'h6E) ? 4'd10 : 4'd0;
    end else begin
      st_mode = M_BAD;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    nf_nxt   = nf_r;
    kw_nxt   = kw_r;
    prev_nxt = prev_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    ts_nxt   = ts_r;
    eb_nxt   = eb_r;
    err_nxt  = err_r;
    n        = 2'd0;
    res      = '0;
    fw       = '0;

    if (!err_r) begin
      if (c == CH_NL) begin
        fw = line_end(mode_nxt, nf_nxt, kw_nxt, prev_r, ts_nxt, eb_nxt, col_nxt, line_nxt);
        if (fw.hit) begin
          res[n] = fw.res;
          n      = n + 2'd1;
        end
        if (fw.fail) err_nxt = 1'b1;
        mode_nxt = M_IDLE;
        line_nxt = sat_inc(line_nxt);
        col_nxt  = '0;
      end else begin
        case (mode_nxt)
          M_IDLE: begin
            if (st_punct) begin
              res[n] = mk_res(st_kind, ERR_NONE, line_nxt, col_r, col_r, 1'b0);
              n      = n + 2'd1;
            end else if (!st_space) begin
              ts_nxt   = col_r;
              mode_nxt = st_mode;
              if (st_mode == M_NUM) nf_nxt = '0;
              if (st_mode == M_KW) kw_nxt = st_kw;
            end
          end
          M_STR: begin
            if (c == CH_BSL) begin
              mode_nxt = M_ESC;
              eb_nxt   = col_r;
            end else if (c == CH_QUOTE) begin
              res[n]   = mk_res(TK_STRING, ERR_NONE, line_nxt, ts_nxt, col_r, 1'b0);
              n        = n + 2'd1;
              mode_nxt = M_IDLE;
            end
          end
          M_ESC: begin
            if (c == 8'h75) begin
              mode_nxt = M_UNI;
              hex_nxt  = 3'd4;
            end else if (c == 8'h6E || c == 8'h74 || c == 8'h66 || c == 8'h62 ||
                         c == 8'h72 || c == CH_SLASH || c == CH_QUOTE || c == CH_BSL) begin
              mode_nxt = M_STR;
            end else begin
              res[n]   = mk_res(TK_LBRACE, ERR_ESCAPE, line_nxt, eb_nxt, col_r, 1'b0);
              n        = n + 2'd1;
              err_nxt  = 1'b1;
              mode_nxt = M_IDLE;
            end
          end
          M_UNI, M_UNIBAD: begin
            if (!is_hex(c)) mode_nxt = M_UNIBAD;
            hex_nxt = hex_nxt - 3'd1;
            if (hex_nxt == 3'd0) begin
              if (mode_nxt == M_UNIBAD) begin
                res[n]   = mk_res(TK_LBRACE, ERR_UNICODE, line_nxt, eb_nxt, col_r, 1'b0);
                n        = n + 2'd1;
                err_nxt  = 1'b1;
                mode_nxt = M_IDLE;
              end else begin
                mode_nxt = M_STR;
              end
            end
          end
          default: begin
            if (is_term(c)) begin
              fw = finish_word(mode_nxt, nf_nxt, kw_nxt, prev_r, ts_nxt,
                               (col_r == '0) ? '0 : col_r - PB'(1), line_nxt);
              if (fw.hit) begin
                res[n] = fw.res;
                n      = n + 2'd1;
              end
              if (fw.fail) err_nxt = 1'b1;
              mode_nxt = M_IDLE;
              if (!err_nxt && st_punct) begin
                res[n] = mk_res(st_kind, ERR_NONE, line_nxt, col_r, col_r, 1'b0);
                n      = n + 2'd1;
              end
            end else if (mode_nxt == M_NUM) begin
              nf_nxt = number_byte(c, prev_r, nf_nxt);
            end else if (mode_nxt == M_KW) begin
              kw_nxt = keyword_byte(c, kw_nxt);
            end
          end
        endcase
        col_nxt = sat_inc(col_nxt);
      end
      prev_nxt = c;

      if (eot && !err_nxt) begin
        fw = line_end(mode_nxt, nf_nxt, kw_nxt, prev_nxt, ts_nxt, eb_nxt, col_nxt, line_nxt);
        if (fw.hit) begin
          res[n] = fw.res;
          n      = n + 2'd1;
        end
        if (fw.fail) begin
          err_nxt = 1'b1;
        end else begin
          res[n] = mk_res(TK_END, ERR_NONE, line_nxt, col_nxt, col_nxt, 1'b0);
          n      = n + 2'd1;
        end
      end
    end

    // The final byte of a document returns everything to its reset value.
    if (eot) begin
      mode_nxt = M_IDLE;
      hex_nxt  = '0;
      nf_nxt   = '0;
      kw_nxt   = '0;
      prev_nxt = '0;
      line_nxt = '0;
      col_nxt  = '0;
      ts_nxt   = '0;
      eb_nxt   = '0;
      err_nxt  = 1'b0;
    end

    if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
  end

  assign bundle = {n, res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      hex_r  <= '0;
      nf_r   <= '0;
      kw_r   <= '0;
      prev_r <= '0;
      line_r <= '0;
      col_r  <= '0;
      ts_r   <= '0;
      eb_r   <= '0;
      err_r  <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      nf_r   <= nf_nxt;
      kw_r   <= kw_nxt;
      prev_r <= prev_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      ts_r   <= ts_nxt;
      eb_r   <= eb_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

### sv/jbt_outbuf.sv
module jbt_outbuf import jbt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  res_bundle_t bundle,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  out_item_t [2:0] slot_r;
  logic [1:0]      cnt_r;
  logic            take;

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = slot_r[0];
  assign take      = out_valid && out_ready;
  // New results may land when none are waiting or the last waiting one leaves in this cycle.
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load && bundle.count != 2'd0) begin
      cnt_r <= bundle.count;
    end else if (take) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && bundle.count != 2'd0) begin
      slot_r <= bundle.item;
    end else if (take) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule
